### rtl/mfle_pkg.sv
// Shared types and byte constants for the mbox From-line escaper.
package mfle_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // CR LF "From "
  localparam logic [7:0] ESC_PAT [7] = '{
    8'h0D, 8'h0A, "F", "r", "o", "m", " "
  };

  // CR LF ">From "
  localparam logic [7:0] ESC_OUT [8] = '{
    8'h0D, 8'h0A, ">", "F", "r", "o", "m", " "
  };

  localparam logic [7:0] SEP_LINE [32] = '{
    "F", "r", "o", "m", " ", "-", " ", "M", "o", "n", " ", "J", "a", "n", " ", "1",
    " ", "0", "0", ":", "0", "0", ":", "0", "0", " ", "1", "9", "6", "5",
    8'h0D, 8'h0A
  };

  typedef struct packed {
    logic [7:0] in_byte;
    logic       message_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_done;
  } out_t;

  // Output plan of one item, segments in emission order.
  typedef struct packed {
    logic       sep;
    logic [2:0] look_n;
    logic [2:0] flush_n;
    logic       esc;
    logic       emit_b;
    logic [7:0] data;
    logic [2:0] tail_n;
    logic       crlf;
  } plan_t;

endpackage

### rtl/mfle_plan.sv
// Per-item decode: message phase tracking and output plan generation.
module mfle_plan (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  mfle_pkg::in_t   item,
  output mfle_pkg::plan_t plan,
  output logic            plan_some
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    PH_LOOK       = 4'b0001,
    PH_SKIP_LINE  = 4'b0010,
    PH_SKIP_SPACE = 4'b0100,
    PH_BODY       = 4'b1000
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  logic [2:0] la_c;
  logic [2:0] bd_c;
  logic [7:0] b;
  logic       is_space;

  assign b        = item.in_byte;
  assign la_c     = (cnt < 3'd6) ? cnt : 3'd0;
  assign bd_c     = (cnt == 3'd7) ? 3'd0 : cnt;
  assign is_space = (b == CH_SPACE) || (b == CH_TAB) ||
                    (b == mfle_pkg::CH_CR) || (b == mfle_pkg::CH_LF);

  always_comb begin
    plan       = '0;
    plan.data  = b;
    phase_next = phase;
    cnt_next   = cnt;
    case (phase)
      PH_LOOK: begin
        if (la_c < 3'd5) begin
          if (b != mfle_pkg::ESC_PAT[la_c + 3'd2]) begin
            plan.sep    = 1'b1;
            plan.look_n = la_c;
            phase_next  = PH_BODY;
            if (b == mfle_pkg::CH_CR) begin
              cnt_next = 3'd1;
            end else begin
              plan.emit_b = 1'b1;
              cnt_next    = 3'd0;
            end
          end else begin
            cnt_next = la_c + 3'd1;
          end
        end else begin
          cnt_next   = 3'd0;
          phase_next = (b == mfle_pkg::CH_CR) ? PH_SKIP_SPACE : PH_SKIP_LINE;
        end
      end
      PH_SKIP_LINE: begin
        if (b == mfle_pkg::CH_CR) begin
          phase_next = PH_SKIP_SPACE;
        end
      end
      PH_SKIP_SPACE: begin
        if (!is_space) begin
          plan.sep    = 1'b1;
          plan.emit_b = 1'b1;
          cnt_next    = 3'd0;
          phase_next  = PH_BODY;
        end
      end
      PH_BODY: begin
        if ((bd_c != 3'd0) && (b == mfle_pkg::ESC_PAT[bd_c])) begin
          if (bd_c == 3'd6) begin
            plan.esc = 1'b1;
            cnt_next = 3'd0;
          end else begin
            cnt_next = bd_c + 3'd1;
          end
        end else begin
          plan.flush_n = bd_c;
          if (b == mfle_pkg::CH_CR) begin
            cnt_next = 3'd1;
          end else begin
            plan.emit_b = 1'b1;
            cnt_next    = 3'd0;
          end
        end
      end
      default: begin
        phase_next = PH_LOOK;
        cnt_next   = 3'd0;
      end
    endcase
    if (item.message_end) begin
      if (phase_next == PH_LOOK) begin
        plan.sep    = 1'b1;
        plan.look_n = cnt_next;
        plan.crlf   = 1'b1;
      end else if (phase_next == PH_BODY) begin
        plan.tail_n = cnt_next;
        plan.crlf   = 1'b1;
      end
      phase_next = PH_LOOK;
      cnt_next   = 3'd0;
    end
  end

  assign plan_some = plan.sep || (plan.look_n != 3'd0) || (plan.flush_n != 3'd0) ||
                     plan.esc || plan.emit_b || (plan.tail_n != 3'd0) || plan.crlf;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LOOK;
      cnt   <= 3'd0;
    end else if (fire) begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

endmodule

### rtl/mfle_emit.sv
// Plan register, segment sequencer and output register.
module mfle_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  mfle_pkg::plan_t plan,
  output logic            busy,
  output logic            out_valid,
  input  logic            out_stall,
  output mfle_pkg::out_t  out_item
);

  typedef enum logic [6:0] {
    SEG_SEP   = 7'b0000001,
    SEG_LOOK  = 7'b0000010,
    SEG_FLUSH = 7'b0000100,
    SEG_ESC   = 7'b0001000,
    SEG_BYTE  = 7'b0010000,
    SEG_TAIL  = 7'b0100000,
    SEG_CRLF  = 7'b1000000
  } seg_t;

  mfle_pkg::plan_t pl;
  logic            plan_valid;
  seg_t            seg;
  logic [4:0]      pos;

  logic [6:0] ne_new;
  logic [6:0] ne_cur;
  logic [6:0] first;
  logic [6:0] above;
  logic [6:0] cand;
  logic [6:0] nxt;
  logic [4:0] lastpos;
  logic [7:0] cur_byte;
  logic       cur_done;
  logic       seg_end;
  logic       last_item;
  logic       go;

  assign ne_new = {plan.crlf, plan.tail_n != 3'd0, plan.emit_b, plan.esc,
                   plan.flush_n != 3'd0, plan.look_n != 3'd0, plan.sep};
  assign ne_cur = {pl.crlf, pl.tail_n != 3'd0, pl.emit_b, pl.esc,
                   pl.flush_n != 3'd0, pl.look_n != 3'd0, pl.sep};
  assign first  = ne_new & (~ne_new + 7'd1);
  assign above  = ~({seg[5:0], 1'b0} - 7'd1);
  assign cand   = ne_cur & above;
  assign nxt    = cand & (~cand + 7'd1);

  always_comb begin
    cur_done = 1'b0;
    case (seg)
      SEG_SEP: begin
        cur_byte = mfle_pkg::SEP_LINE[pos];
        lastpos  = 5'd31;
      end
      SEG_LOOK: begin
        cur_byte = mfle_pkg::ESC_PAT[pos[2:0] + 3'd2];
        lastpos  = {2'b00, pl.look_n} - 5'd1;
      end
      SEG_FLUSH: begin
        cur_byte = mfle_pkg::ESC_PAT[pos[2:0]];
        lastpos  = {2'b00, pl.flush_n} - 5'd1;
      end
      SEG_ESC: begin
        cur_byte = mfle_pkg::ESC_OUT[pos[2:0]];
        lastpos  = 5'd7;
      end
      SEG_BYTE: begin
        cur_byte = pl.data;
        lastpos  = 5'd0;
      end
      SEG_TAIL: begin
        cur_byte = mfle_pkg::ESC_PAT[pos[2:0]];
        lastpos  = {2'b00, pl.tail_n} - 5'd1;
      end
      SEG_CRLF: begin
        cur_byte = pos[0] ? mfle_pkg::CH_LF : mfle_pkg::CH_CR;
        cur_done = pos[0];
        lastpos  = 5'd1;
      end
      default: begin
        cur_byte = 8'h00;
        lastpos  = 5'd0;
      end
    endcase
  end

  assign seg_end   = (pos == lastpos);
  assign last_item = seg_end && (cand == 7'd0);
  assign go        = plan_valid && (!out_valid || !out_stall);
  assign busy      = plan_valid && !(go && last_item);

  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
      out_valid  <= 1'b0;
      seg        <= SEG_SEP;
      pos        <= 5'd0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        plan_valid <= 1'b1;
        seg        <= seg_t'(first);
        pos        <= 5'd0;
      end else if (go) begin
        if (last_item) begin
          plan_valid <= 1'b0;
        end else if (seg_end) begin
          seg <= seg_t'(nxt);
          pos <= 5'd0;
        end else begin
          pos <= pos + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pl <= plan;
    end
    if (go) begin
      out_item.out_byte     <= cur_byte;
      out_item.run_last     <= last_item;
      out_item.message_done <= cur_done;
    end
  end

endmodule

### rtl/mbox_from_line_escaper.sv
// Top level of the mbox From-line escaper.
//
// Usage: message body bytes enter on the byte channel (byte_valid, byte_stall,
// byte_item), message_end set on the last byte of each message. Escaped mbox
// bytes leave on the mbox channel (mbox_valid, mbox_stall, mbox_item).
// A fixed separator line opens each message's output; a leading "From " line
// and the whitespace after it are dropped. CR LF "From " in the body becomes
// CR LF ">From ", and CR LF closes each message that has output (message_done
// on that LF). run_last flags the final byte that one input item produced.
// The plan of an accepted item is registered in the plan register; its bytes
// then leave through the output register. The input is held while the
// sequencer emits an item's bytes, one byte per cycle while mbox_stall is
// low; an item producing no bytes loads no plan. Plain body bytes flow at one
// per cycle while mbox_stall is low. Worst case is a burst of up to 39 bytes.
// Reset (rst, synchronous) empties the pipeline and starts a new message.
// When mbox_stall is high the output item holds and, once the plan register
// is occupied, byte_stall rises.
module mbox_from_line_escaper (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_stall,
  input  mfle_pkg::in_t  byte_item,
  output logic           mbox_valid,
  input  logic           mbox_stall,
  output mfle_pkg::out_t mbox_item
);

  mfle_pkg::plan_t plan;
  logic            plan_some;
  logic            busy;
  logic            fire;

  assign byte_stall = busy;
  assign fire       = byte_valid && !busy;

  mfle_plan u_plan (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (byte_item),
    .plan      (plan),
    .plan_some (plan_some)
  );

  mfle_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && plan_some),
    .plan      (plan),
    .busy      (busy),
    .out_valid (mbox_valid),
    .out_stall (mbox_stall),
    .out_item  (mbox_item)
  );

endmodule

### rtl/mfle_check.sv
// Port-level checker for the mbox From-line escaper, bound to the top level.
module mfle_check (
  input logic           clk,
  input logic           rst,
  input logic           byte_valid,
  input logic           byte_stall,
  input mfle_pkg::in_t  byte_item,
  input logic           mbox_valid,
  input logic           mbox_stall,
  input mfle_pkg::out_t mbox_item
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !mbox_valid)
    else $error("output valid right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
    else $error("stalled input item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    mbox_valid && mbox_stall |=> mbox_valid && $stable(mbox_item))
    else $error("stalled output item changed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    mbox_valid && mbox_item.message_done |->
      mbox_item.run_last && (mbox_item.out_byte == mfle_pkg::CH_LF))
    else $error("message_done not on the final LF");

  a_pending_moves: assert property (@(posedge clk) disable iff (rst)
    byte_stall && !mbox_stall |=> mbox_valid)
    else $error("pending output not delivered");

endmodule

bind mbox_from_line_escaper mfle_check u_check (.*);

### tb/mbox_from_line_escaper_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the mbox From-line escaper: random and directed messages.
module mbox_from_line_escaper_test;

  localparam int RANDOM_ITEMS = 350;
  localparam int CALM_ITEMS = 60;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef enum logic [1:0] {
    PH_LOOKAHEAD  = 2'd0,
    PH_SKIP_LINE  = 2'd1,
    PH_SKIP_SPACE = 2'd2,
    PH_BODY       = 2'd3
  } phase_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           byte_valid = 1'b0;
  logic           byte_stall;
  mfle_pkg::in_t  byte_item = '0;
  logic           mbox_valid;
  logic           mbox_stall = 1'b0;
  mfle_pkg::out_t mbox_item;

  mfle_pkg::in_t  byte_pend_q [$];
  mfle_pkg::out_t mbox_exp_q [$];
  logic [7:0]     msg_q [$];

  // escaper state mirror
  logic [7:0]     held_win [7] = '{default: 8'h00};
  int unsigned    held_n = 0;
  phase_t         ph = PH_LOOKAHEAD;
  logic           sep_sent = 1'b0;
  mfle_pkg::out_t staged;
  logic           staged_ok = 1'b0;

  int          error_count = 0;
  int          idle_cycles = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  logic        calm = 1'b0;

  mbox_from_line_escaper dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .mbox_valid (mbox_valid),
    .mbox_stall (mbox_stall),
    .mbox_item  (mbox_item)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
    error_count++;
  endtask

  // last byte of an item is held back so run_last can be set on it
  function automatic void push_byte(logic [7:0] b, logic done);
    if (staged_ok) mbox_exp_q.push_back(staged);
    staged.out_byte = b;
    staged.run_last = 1'b0;
    staged.message_done = done;
    staged_ok = 1'b1;
  endfunction

  function automatic void flush_held();
    int unsigned n;
    n = (held_n < 7) ? held_n : 0;
    for (int unsigned i = 0; i < n; i++) push_byte(held_win[i], 1'b0);
    held_n = 0;
  endfunction

  function automatic void body_byte(logic [7:0] b);
    int unsigned c;
    c = (held_n < 7) ? held_n : 0;
    if (c > 0 && b == mfle_pkg::ESC_PAT[c]) begin
      held_win[c] = b;
      c++;
      held_n = c;
      if (c == 7) begin
        for (int i = 0; i < 8; i++) push_byte(mfle_pkg::ESC_OUT[i], 1'b0);
        held_n = 0;
      end
      return;
    end
    held_n = c;
    flush_held();
    if (b == mfle_pkg::CH_CR) begin
      held_win[0] = b;
      held_n = 1;
    end else begin
      push_byte(b, 1'b0);
    end
  endfunction

  function automatic void start_body();
    logic [7:0]  kept [7];
    int unsigned n;
    kept = held_win;
    n = (held_n < 7) ? held_n : 0;
    held_n = 0;
    for (int i = 0; i < 32; i++) push_byte(mfle_pkg::SEP_LINE[i], 1'b0);
    sep_sent = 1'b1;
    ph = PH_BODY;
    for (int unsigned i = 0; i < n; i++) body_byte(kept[i]);
  endfunction

  function automatic void predict_item(mfle_pkg::in_t it);
    logic [7:0]  b;
    int unsigned c;
    b = it.in_byte;
    staged_ok = 1'b0;
    case (ph)
      PH_LOOKAHEAD: begin
        c = (held_n < 6) ? held_n : 0;
        held_win[c] = b;
        c++;
        held_n = c;
        if (c <= 5) begin
          if (b != mfle_pkg::ESC_PAT[c + 1]) start_body();
        end else begin
          held_n = 0;
          ph = (b == mfle_pkg::CH_CR) ? PH_SKIP_SPACE : PH_SKIP_LINE;
        end
      end
      PH_SKIP_LINE: begin
        if (b == mfle_pkg::CH_CR) ph = PH_SKIP_SPACE;
      end
      PH_SKIP_SPACE: begin
        if (!(b == CH_SP || b == CH_TAB || b == mfle_pkg::CH_CR || b == mfle_pkg::CH_LF))
        begin
          held_n = 0;
          start_body();
          body_byte(b);
        end
      end
      default: body_byte(b);
    endcase
    if (it.message_end) begin
      if (ph == PH_LOOKAHEAD) start_body();
      if (ph == PH_BODY) begin
        flush_held();
        push_byte(mfle_pkg::CH_CR, 1'b0);
        push_byte(mfle_pkg::CH_LF, 1'b1);
      end
      held_n = 0;
      ph = PH_LOOKAHEAD;
      sep_sent = 1'b0;
    end
    if (staged_ok) begin
      staged.run_last = 1'b1;
      mbox_exp_q.push_back(staged);
      staged_ok = 1'b0;
    end
  endfunction

  function automatic void put_byte(logic [7:0] b);
    msg_q.push_back(b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void close_message();
    mfle_pkg::in_t it;
    if (msg_q.size() == 0) put_byte(8'($urandom_range(0, 255)));
    for (int i = 0; i < msg_q.size(); i++) begin
      it.in_byte = msg_q[i];
      it.message_end = (i == msg_q.size() - 1);
      byte_pend_q.push_back(it);
    end
    msg_q.delete();
  endfunction

  function automatic logic [7:0] white_byte();
    case ($urandom_range(0, 3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return mfle_pkg::CH_CR;
      default: return mfle_pkg::CH_LF;
    endcase
  endfunction

  function automatic void add_random_message();
    int unsigned kind, n, k, m;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      n = $urandom_range(1, 8);
      for (int unsigned i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
    end else begin
      if (kind < 5) begin
        put_text("From ");
        n = $urandom_range(0, 6);
        for (int unsigned i = 0; i < n; i++) put_byte(8'($urandom_range(8'h21, 8'h7E)));
        put_byte(mfle_pkg::CH_CR);
        put_byte(mfle_pkg::CH_LF);
        n = $urandom_range(0, 3);
        for (int unsigned i = 0; i < n; i++) put_byte(white_byte());
      end else if (kind < 7) begin
        n = $urandom_range(1, 4);
        for (int unsigned i = 0; i < n; i++) put_byte(mfle_pkg::ESC_PAT[i + 2]);
        put_byte(8'($urandom_range(0, 255)));
      end
      n = $urandom_range(0, 4);
      for (int unsigned i = 0; i < n; i++) begin
        k = $urandom_range(0, 5);
        case (k)
          0: begin
            m = $urandom_range(1, 4);
            for (int unsigned j = 0; j < m; j++) put_byte(8'($urandom_range(0, 255)));
          end
          1: begin
            put_byte(mfle_pkg::CH_CR);
            put_byte(mfle_pkg::CH_LF);
          end
          2: for (int j = 0; j < 7; j++) put_byte(mfle_pkg::ESC_PAT[j]);
          3: begin
            m = $urandom_range(1, 6);
            for (int unsigned j = 0; j < m; j++) put_byte(mfle_pkg::ESC_PAT[j]);
          end
          4: put_text("From ");
          default: begin
            m = $urandom_range(1, 5);
            for (int unsigned j = 0; j < m; j++) put_byte(8'($urandom_range(8'h20, 8'h7E)));
          end
        endcase
      end
    end
    close_message();
  endfunction

  always @(posedge clk) begin : drive
    mfle_pkg::in_t nxt;
    if (rst) begin
      byte_valid <= 1'b0;
      src_gap <= 0;
    end else if (!byte_valid || !byte_stall) begin
      if (src_gap > 0) begin
        byte_valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (byte_pend_q.size() > 0) begin
        nxt = byte_pend_q.pop_front();
        byte_item <= nxt;
        byte_valid <= 1'b1;
        if (byte_pend_q.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
          src_gap <= $urandom_range(1, 8);
      end else begin
        byte_valid <= 1'b0;
      end
    end
    calm <= (byte_pend_q.size() < CALM_ITEMS);
  end

  always @(posedge clk) begin : sink
    if (rst) begin
      mbox_stall <= 1'b0;
      sink_gap <= 0;
    end else if (sink_gap > 0) begin
      mbox_stall <= 1'b1;
      sink_gap <= sink_gap - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      mbox_stall <= 1'b1;
      sink_gap <= $urandom_range(0, 7);
    end else begin
      mbox_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : watch
    mfle_pkg::out_t want;
    logic moved;
    if (!rst) begin
      moved = 1'b0;
      if (byte_valid && !byte_stall) begin
        predict_item(byte_item);
        moved = 1'b1;
      end
      if (mbox_valid && !mbox_stall) begin
        moved = 1'b1;
        if (mbox_exp_q.size() == 0) begin
          report_mismatch("unexpected item, out_byte", mbox_item.out_byte, 0);
        end else begin
          want = mbox_exp_q.pop_front();
          if (mbox_item.out_byte !== want.out_byte)
            report_mismatch("out_byte", mbox_item.out_byte, want.out_byte);
          if (mbox_item.run_last !== want.run_last)
            report_mismatch("run_last", mbox_item.run_last, want.run_last);
          if (mbox_item.message_done !== want.message_done)
            report_mismatch("message_done", mbox_item.message_done, want.message_done);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main
    int directed_n;
    // short message, never a From line
    put_text("From ");
    close_message();
    // From line covering the whole message
    put_text("From x");
    close_message();
    // body right after the skip starts with From, left alone
    put_text("From ");
    put_byte(mfle_pkg::CH_CR);
    put_text("From ");
    close_message();
    // partial escape match at the end
    put_byte(8'hFF);
    put_byte(mfle_pkg::CH_CR);
    put_byte(mfle_pkg::CH_LF);
    put_text("Fr");
    close_message();
    directed_n = byte_pend_q.size();
    while (byte_pend_q.size() < directed_n + RANDOM_ITEMS) add_random_message();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (byte_pend_q.size() > 0 || byte_valid) @(negedge clk);
    while (mbox_exp_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
